// File: hdl/kwm_pkg.sv
// Shared types, constants and codes for the k-way merge min-heap unit.
package kwm_pkg;

  // Heap sizing
  localparam int NUM_SOURCES = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SRC_W       = 4;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CNT_W       = $clog2(NUM_SOURCES + 1);
  localparam int CHILD_W     = IDX_W + 2;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_POPPED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [MODE_W-1:0]             mode;
    logic [SRC_W-1:0]              source;
    logic signed [VALUE_WIDTH-1:0] value;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [STATUS_W-1:0]           status;
    logic signed [VALUE_WIDTH-1:0] min_value;
    logic [SRC_W-1:0]              min_source;
  } out_t;

  // One heap slot
  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [SRC_W-1:0]              source;
  } entry_t;

endpackage

// File: hdl/kwm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/kwm_cmp.sv
// Heap order compare: smaller value first, lower source on equal values.
module kwm_cmp (
  input  kwm_pkg::entry_t a_i,
  input  kwm_pkg::entry_t b_i,
  output logic            a_first_o
);
  import kwm_pkg::*;

  logic val_lt;
  logic val_eq;

  assign val_lt    = a_i.value < b_i.value;
  assign val_eq    = a_i.value == b_i.value;
  assign a_first_o = val_lt || (val_eq && (a_i.source < b_i.source));

endmodule

// File: hdl/k_way_merge_min_heap_unit.sv
// Top level of the k-way merge min-heap unit: sequencer, heap RAM and compare.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_data_i  (mode,source,value)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (status,value,src)
//
// One transaction at a time; the heap lives in a RAM with one write and one
// registered read port, so each heap level costs a read plus a compare.
// A push climbs one heap level per parent read and compare, moving each losing parent
// down and writing the entry at the root or where it stops; a pop fetches the root and
// the last entry, then sifts down, reading the left and right child and comparing,
// until it settles at a leaf or after a losing compare; a pop that empties the heap
// skips the sift; clear, full, empty and unknown modes go straight to the result.
// The next transaction is taken from idle, after the result loads. Reset empties the heap
// (count only). A stalled output holds the finished result and the sequencer waits.
module k_way_merge_min_heap_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kwm_pkg::in_t    in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output kwm_pkg::out_t   out_data_o
);
  import kwm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_PO_RD0,
    ST_PO_RES,
    ST_PO_LAST,
    ST_DN_L,
    ST_DN_LD,
    ST_DN_R,
    ST_DN_C,
    ST_OUT
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   hole_q, hole_d;
  logic [IDX_W-1:0]   cidx_q, cidx_d;
  entry_t             ent_q, ent_d;
  entry_t             cand_q, cand_d;
  out_t               res_q, res_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;

  // RAM and compare unit hookup
  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic [IDX_W-1:0]   raddr;
  entry_t             rdata;
  entry_t             cmp_a;
  entry_t             cmp_b;
  logic               a_first;

  // Index arithmetic
  logic [IDX_W-1:0]   parent;
  logic [CHILD_W-1:0] left;
  logic [CHILD_W-1:0] right;
  logic [CHILD_W-1:0] count_ext;
  logic [CNT_W-1:0]   count_dec;

  assign parent    = (hole_q - IDX_W'(1)) >> 1;
  assign left      = {1'b0, hole_q, 1'b1};
  assign right     = left + CHILD_W'(1);
  assign count_ext = CHILD_W'(count_q);
  assign count_dec = count_q - CNT_W'(1);

  kwm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_SOURCES)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  kwm_cmp u_cmp (
    .a_i       (cmp_a),
    .b_i       (cmp_b),
    .a_first_o (a_first)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Sequencer next-state and datapath control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    hole_d      = hole_q;
    cidx_d      = cidx_q;
    ent_d       = ent_q;
    cand_d      = cand_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    we          = 1'b0;
    waddr       = hole_q;
    wdata       = ent_q;
    raddr       = '0;
    cmp_a       = ent_q;
    cmp_b       = rdata;

    // output register drains when taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = ST_OUT;
          case (in_data_i.mode)
            MODE_PUSH: begin
              if (count_q >= CNT_W'(NUM_SOURCES)) begin
                res_d.status = STAT_FULL;
              end else begin
                ent_d.value  = in_data_i.value;
                ent_d.source = in_data_i.source;
                hole_d       = count_q[IDX_W-1:0];
                count_d      = count_q + CNT_W'(1);
                state_d      = ST_UP;
              end
            end
            MODE_POP: begin
              if (count_q == '0) begin
                res_d.status = STAT_EMPTY;
              end else begin
                state_d = ST_PO_RD0;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
              // meaningless mode: heap untouched, status OK
            end
          endcase
        end
      end

      // sift up: write at the root, else read the parent of the hole
      ST_UP: begin
        if (hole_q == '0) begin
          we      = 1'b1;
          state_d = ST_OUT;
        end else begin
          raddr   = parent;
          state_d = ST_UP_CMP;
        end
      end

      // new entry beats parent: move parent down into the hole; else write the entry there
      ST_UP_CMP: begin
        we = 1'b1;
        if (a_first) begin
          wdata   = rdata;
          hole_d  = parent;
          state_d = ST_UP;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_PO_RD0: begin
        raddr   = '0;
        state_d = ST_PO_RES;
      end

      // root arrives: that is the result; fetch the last entry
      ST_PO_RES: begin
        res_d.status     = STAT_POPPED;
        res_d.min_value  = rdata.value;
        res_d.min_source = rdata.source;
        count_d          = count_dec;
        if (count_dec == '0) begin
          state_d = ST_OUT;
        end else begin
          raddr   = count_dec[IDX_W-1:0];
          state_d = ST_PO_LAST;
        end
      end

      ST_PO_LAST: begin
        ent_d   = rdata;
        hole_d  = '0;
        state_d = ST_DN_L;
      end

      // sift down: read left child, or settle if there is none
      ST_DN_L: begin
        if (left >= count_ext) begin
          we      = 1'b1;
          state_d = ST_OUT;
        end else begin
          raddr   = left[IDX_W-1:0];
          state_d = ST_DN_LD;
        end
      end

      ST_DN_LD: begin
        cand_d = rdata;
        cidx_d = left[IDX_W-1:0];
        if (right < count_ext) begin
          raddr   = right[IDX_W-1:0];
          state_d = ST_DN_R;
        end else begin
          state_d = ST_DN_C;
        end
      end

      // pick the better of the two children
      ST_DN_R: begin
        cmp_a = rdata;
        cmp_b = cand_q;
        if (a_first) begin
          cand_d = rdata;
          cidx_d = right[IDX_W-1:0];
        end
        state_d = ST_DN_C;
      end

      // child beats the carried entry: move child up into the hole; else write the entry there
      ST_DN_C: begin
        cmp_a = cand_q;
        cmp_b = ent_q;
        we    = 1'b1;
        if (a_first) begin
          wdata   = cand_q;
          hole_d  = cidx_q;
          state_d = ST_DN_L;
        end else begin
          state_d = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      hole_q      <= '0;
      cidx_q      <= '0;
      ent_q       <= '0;
      cand_q      <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      hole_q      <= hole_d;
      cidx_q      <= cidx_d;
      ent_q       <= ent_d;
      cand_q      <= cand_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

endmodule

// File: dv/tb_k_way_merge_min_heap_unit.sv
// Self-checking testbench for the k-way merge min-heap unit: merge sequences, noise, stalls.
module tb_k_way_merge_min_heap_unit;
  import kwm_pkg::*;

  // Mode 3 carries no operation; the unit must ignore it
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;

  // Heap predictor plus the queue of results still owed by the unit
  class heap_scoreboard;
    entry_t slots [NUM_SOURCES];
    int unsigned fill;
    out_t owed_results[$];
    int unsigned errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    // Smaller value first, lower source on a tie
    function bit ahead(entry_t a, entry_t b);
      if (a.value != b.value) return $signed(a.value) < $signed(b.value);
      return a.source < b.source;
    endfunction

    function void swap_slots(int unsigned i, int unsigned j);
      entry_t tmp;
      tmp = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    endfunction

    // Apply one accepted transaction to the shadow heap and queue its result
    function out_t note_request(in_t req);
      out_t res;
      int unsigned idx;
      int unsigned parent;
      int unsigned lc;
      int unsigned rc;
      int unsigned best;
      res = '0;
      res.status = STAT_OK;
      case (req.mode)
        MODE_PUSH: begin
          if (fill >= NUM_SOURCES) begin
            res.status = STAT_FULL;
          end else begin
            idx = fill;
            slots[idx].value = req.value;
            slots[idx].source = req.source;
            fill++;
            while (idx > 0) begin
              parent = (idx - 1) / 2;
              if (!ahead(slots[idx], slots[parent])) break;
              swap_slots(idx, parent);
              idx = parent;
            end
          end
        end
        MODE_POP: begin
          if (fill == 0) begin
            res.status = STAT_EMPTY;
          end else begin
            res.status = STAT_POPPED;
            res.min_value = slots[0].value;
            res.min_source = slots[0].source;
            fill--;
            if (fill > 0) begin
              slots[0] = slots[fill];
              idx = 0;
              while (1) begin
                lc = 2 * idx + 1;
                rc = lc + 1;
                best = idx;
                if (lc < fill && ahead(slots[lc], slots[best])) best = lc;
                if (rc < fill && ahead(slots[rc], slots[best])) best = rc;
                if (best == idx) break;
                swap_slots(idx, best);
                idx = best;
              end
            end
          end
        end
        MODE_CLEAR: fill = 0;
        default: ;
      endcase
      owed_results.insert(owed_results.size(), res);
      return res;
    endfunction

    // Compare one delivered result against the oldest owed one
    function void check_result(out_t got);
      out_t exp;
      if (owed_results.size() == 0) begin
        $error("result with nothing pending: status %0d value %0d source %0d",
               got.status, got.min_value, got.min_source);
        errors++;
        return;
      end
      exp = owed_results.pop_front();
      if (got.status !== exp.status) begin
        $error("status mismatch: expected %0d, got %0d", exp.status, got.status);
        errors++;
      end
      if (got.min_value !== exp.min_value) begin
        $error("min_value mismatch: expected %0d, got %0d", exp.min_value, got.min_value);
        errors++;
      end
      if (got.min_source !== exp.min_source) begin
        $error("min_source mismatch: expected %0d, got %0d", exp.min_source,
               got.min_source);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  heap_scoreboard sb = new();

  int items_sent = 0;
  int send_idle_pct = 16;
  int recv_idle_pct = 50;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;

  k_way_merge_min_heap_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Clock
  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Drive one transaction, wait for acceptance, return the predicted result
  task automatic issue_op(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] src,
                          input logic [VALUE_WIDTH-1:0] val, output out_t pred);
    in_t item;
    item.mode = mode;
    item.source = src;
    item.value = val;
    // idle mix by progress: sender-heavy, receiver-heavy, then none
    if (items_sent < 460) begin
      send_idle_pct = 16;
      recv_idle_pct = 50;
    end else if (items_sent < 920) begin
      send_idle_pct = 50;
      recv_idle_pct = 16;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (items_sent == 300 || items_sent == 1000) hold_requests++;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (in_stall);
    pred = sb.note_request(item);
    items_sent++;
  endtask

  // Extremes, ties, full heap, empty heap, clear and the unused mode
  task automatic directed_ops();
    out_t pred;
    issue_op(MODE_PUSH, 4'd3, 32'd0, pred);
    issue_op(MODE_PUSH, 4'd15, 32'h7fff_ffff, pred);
    issue_op(MODE_PUSH, 4'd0, 32'h8000_0000, pred);
    issue_op(MODE_PUSH, 4'd5, 32'hffff_ffff, pred);
    issue_op(MODE_PUSH, 4'd2, 32'd7, pred);
    issue_op(MODE_PUSH, 4'd9, 32'd7, pred);
    issue_op(MODE_PUSH, 4'd1, 32'd7, pred);
    for (int i = 0; i < 9; i++) begin
      issue_op(MODE_PUSH, 4'(15 - i), 32'(i * 1000 - 3000), pred);
    end
    issue_op(MODE_PUSH, 4'd4, 32'd1, pred);       // heap full: dropped
    issue_op(MODE_UNUSED, 4'd6, 32'd5, pred);
    repeat (3) issue_op(MODE_POP, 4'd0, 32'd0, pred);
    issue_op(MODE_CLEAR, 4'd0, 32'd0, pred);
    issue_op(MODE_POP, 4'd0, 32'd0, pred);        // empty heap
    issue_op(MODE_PUSH, 4'd15, 32'h7fff_ffff, pred);
    issue_op(MODE_POP, 4'd15, 32'hffff_ffff, pred);
  endtask

  // One merge of sorted streams; sometimes starts dirty or stops early
  task automatic merge_streams();
    int stream [16][$];
    int ids [16];
    int k;
    int len;
    int tmp;
    int j;
    int pops;
    int abort_after;
    bit narrow;
    out_t pred;
    narrow = ($urandom_range(0, 2) == 0);
    k = $urandom_range(2, 16);
    for (int i = 0; i < 16; i++) ids[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    for (int n = 0; n < k; n++) begin
      len = $urandom_range(0, 6);
      for (int e = 0; e < len; e++) begin
        stream[ids[n]].insert(stream[ids[n]].size(),
                              narrow ? $urandom_range(0, 8) - 4 : int'($urandom));
      end
      stream[ids[n]].sort();
    end
    if ($urandom_range(0, 3) != 0) issue_op(MODE_CLEAR, 4'($urandom), $urandom, pred);
    // heads first
    for (int n = 0; n < k; n++) begin
      if (stream[ids[n]].size() > 0) begin
        issue_op(MODE_PUSH, 4'(ids[n]), stream[ids[n]].pop_front(), pred);
      end
    end
    abort_after = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : 1000;
    pops = 0;
    while (1) begin
      issue_op(MODE_POP, 4'($urandom), $urandom, pred);
      if (pred.status != STAT_POPPED) break;
      pops++;
      if (stream[pred.min_source].size() > 0) begin
        issue_op(MODE_PUSH, pred.min_source, stream[pred.min_source].pop_front(), pred);
      end
      if (pops >= abort_after) break;
    end
  endtask

  // Random burst of any mode, push-heavy so the heap fills and drops
  task automatic noise_burst();
    int n;
    int r;
    logic [MODE_W-1:0] mode;
    logic [VALUE_WIDTH-1:0] val;
    out_t pred;
    n = $urandom_range(5, 30);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 55) mode = MODE_PUSH;
      else if (r < 85) mode = MODE_POP;
      else if (r < 93) mode = MODE_CLEAR;
      else mode = MODE_UNUSED;
      case ($urandom_range(0, 19))
        0: val = 32'h8000_0000;
        1: val = 32'h7fff_ffff;
        2: val = 32'hffff_ffff;
        3: val = 32'd0;
        default: val = $urandom;
      endcase
      issue_op(mode, 4'($urandom), val, pred);
    end
  endtask

  // Stimulus and end of run
  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_ops();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) noise_burst();
      else merge_streams();
    end
    in_valid <= 1'b0;
    while (sb.owed_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: k_way_merge_min_heap_unit.f
hdl/kwm_pkg.sv
hdl/kwm_ram.sv
hdl/kwm_cmp.sv
hdl/k_way_merge_min_heap_unit.sv
dv/tb_k_way_merge_min_heap_unit.sv
